FILE: sv/bfe_pkg.sv
// Shared types and constants for the framed byte-stream encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bfe_pkg;

    // Width of the frame length counter; the header carries the length zero-extended to 16 bits.
    localparam int LENGTH_BITS = 15;
    localparam int SUM_BITS    = 15;
    localparam int MAXLEN_BITS = 15;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MAXLEN_BITS-1:0] MAXLEN_RESET = MAXLEN_BITS'(992);

    // Framing bytes.
    localparam logic [7:0] SYNC_BYTE0 = 8'hA0;
    localparam logic [7:0] SYNC_BYTE1 = 8'hA2;
    localparam logic [7:0] END_BYTE0  = 8'hB0;
    localparam logic [7:0] END_BYTE1  = 8'hB3;

    // Positions of a byte within the sequence a single job can emit.
    typedef enum logic [3:0] {
        POS_SYNC0   = 4'd0,
        POS_SYNC1   = 4'd1,
        POS_LEN_HI  = 4'd2,
        POS_LEN_LO  = 4'd3,
        POS_PAYLOAD = 4'd4,
        POS_SUM_HI  = 4'd5,
        POS_SUM_LO  = 4'd6,
        POS_END0    = 4'd7,
        POS_END1    = 4'd8
    } pos_t;

    // One classified input item, as handed from front to back.
    typedef struct packed {
        logic                   reject;
        logic                   header;
        logic                   trailer;
        logic [7:0]             data;
        logic [LENGTH_BITS-1:0] length;
        logic [SUM_BITS-1:0]    sum;
    } job_t;

endpackage

`default_nettype wire

FILE: sv/bfe_front.sv
// Front end of the framed encoder: accepts payload bytes, tracks frame state
// and turns each byte into a job. Depends on bfe_pkg.
`default_nettype none

module bfe_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [14:0]                   cfg_data,
    input  wire logic                          in_accept,
    input  wire logic [7:0]                    payload_byte,
    input  wire logic [14:0]                   frame_length,
    output bfe_pkg::job_t                      job,
    output logic                               job_valid
);
    import bfe_pkg::*;

    logic [MAXLEN_BITS-1:0] max_len_reg;
    logic                   in_frame_reg, in_frame_next;
    logic                   dropping_reg, dropping_next;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [LENGTH_BITS-1:0] len;
    logic                   bad_len;

    assign len     = LENGTH_BITS'(frame_length);
    assign bad_len = (len == '0) || (17'(len) > 17'(max_len_reg));

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        dropping_next   = dropping_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        job             = '0;
        job.data        = payload_byte;
        job.length      = len;
        job_valid       = in_accept && !dropping_reg;

        if (dropping_reg)
        begin
            bytes_left_next = bytes_left_reg - 1'b1;
            dropping_next   = (bytes_left_next != '0);
        end
        else if (!in_frame_reg)
        begin
            if (bad_len)
            begin
                job.reject      = 1'b1;
                bytes_left_next = (len == '0) ? '0 : len - 1'b1;
                dropping_next   = (bytes_left_next != '0);
            end
            else
            begin
                job.header      = 1'b1;
                sum_next        = SUM_BITS'(payload_byte);
                bytes_left_next = len - 1'b1;
                job.trailer     = (bytes_left_next == '0);
                in_frame_next   = !job.trailer;
            end
        end
        else
        begin
            sum_next        = sum_reg + SUM_BITS'(payload_byte);
            bytes_left_next = bytes_left_reg - 1'b1;
            job.trailer     = (bytes_left_next == '0);
            in_frame_next   = !job.trailer;
        end
        job.sum = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= MAXLEN_RESET;
            in_frame_reg   <= 1'b0;
            dropping_reg   <= 1'b0;
            bytes_left_reg <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_data;
            end
            if (in_accept)
            begin
                in_frame_reg   <= in_frame_next;
                dropping_reg   <= dropping_next;
                bytes_left_reg <= bytes_left_next;
                sum_reg        <= sum_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/bfe_queue.sv
// Short job queue that decouples the encoder front from its back end.
// Depends on bfe_pkg.
`default_nettype none

module bfe_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire bfe_pkg::job_t wr_job,
    output logic               full,
    input  wire logic          rd_en,
    output bfe_pkg::job_t      rd_job,
    output logic               empty
);
    import bfe_pkg::*;

    job_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_wr, do_rd;

    assign full   = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
        return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/bfe_back.sv
// Back end of the framed encoder: expands each queued job into header,
// payload and trailer bytes, one per transfer. Depends on bfe_pkg.
`default_nettype none

module bfe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bfe_pkg::job_t job,
    input  wire logic          job_empty,
    output logic               job_pop,
    input  wire logic          pop,
    output logic [7:0]         out_byte,
    output logic               last_of_run,
    output logic               end_of_frame,
    output logic               rejected
);
    import bfe_pkg::*;

    logic [3:0]  step_reg, step_next;
    pos_t        pos;
    pos_t        last_pos;
    logic        xfer;
    logic [15:0] len16;
    logic [15:0] sum16;

    assign len16    = 16'(job.length);
    assign sum16    = 16'(job.sum);
    assign pos      = pos_t'(step_reg + (job.header ? 4'(POS_SYNC0) : 4'(POS_PAYLOAD)));
    assign last_pos = job.trailer ? POS_END1 : POS_PAYLOAD;
    assign xfer     = pop && !job_empty;

    assign last_of_run  = job.reject || (pos == last_pos);
    assign end_of_frame = !job.reject && (pos == POS_END1);
    assign rejected     = job.reject;
    assign job_pop      = xfer && last_of_run;

    always_comb
    begin
        if (job.reject)
        begin
            out_byte = 8'h00;
        end
        else
        begin
            unique case (pos)
                POS_SYNC0:   out_byte = SYNC_BYTE0;
                POS_SYNC1:   out_byte = SYNC_BYTE1;
                POS_LEN_HI:  out_byte = len16[15:8];
                POS_LEN_LO:  out_byte = len16[7:0];
                POS_PAYLOAD: out_byte = job.data;
                POS_SUM_HI:  out_byte = sum16[15:8];
                POS_SUM_LO:  out_byte = sum16[7:0];
                POS_END0:    out_byte = END_BYTE0;
                POS_END1:    out_byte = END_BYTE1;
                default:     out_byte = 8'h00;
            endcase
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (xfer)
        begin
            step_next = last_of_run ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 4'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/binary_frame_encoder_sum_checksum_top.sv
// Top level of the framed byte-stream encoder with 15-bit sum checksum.
// Instantiates bfe_front, bfe_queue and bfe_back; depends on bfe_pkg.
//
// Payload bytes go in through a queue-style port (push/full), one per
// transfer; frame_length is sampled on the first byte of each frame. The
// block emits A0 A2, the 16-bit big-endian length, the payload bytes, the
// big-endian 15-bit sum of the payload bytes, then B0 B3, one byte per
// transfer on the result side (empty/pop). A frame whose length is zero or
// above max_payload_len gives a single result with rejected set and byte 0,
// and its remaining bytes are consumed without output. last_of_run marks
// the final byte caused by each input byte; end_of_frame marks the B3 byte.
// Rate: the input takes one byte per cycle while full is low; the output
// moves one byte per cycle while pop is high and empty low. A middle byte
// gives one result byte, the first byte of a frame five (four header bytes
// plus itself), the last byte five (itself plus four trailer bytes) and a
// one-byte frame nine. Dropped bytes of a rejected frame give none. The
// output side sets the sustained rate; a two-entry job queue between the
// classifying front and the expanding back absorbs short stalls on either
// side. max_payload_len is written through cfg_valid/cfg_data (always
// ready) and resets to 992; write it only while the block is idle.
`default_nettype none

module binary_frame_encoder_sum_checksum_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input queue
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [14:0] frame_length,
    // result queue
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             end_of_frame,
    output logic             rejected,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [14:0] cfg_data
);
    import bfe_pkg::*;

    job_t front_job;
    job_t head_job;
    logic front_job_valid;
    logic in_accept;
    logic queue_empty;
    logic job_pop;

    // Configuration writes never stall.
    assign cfg_ready = 1'b1;

    // Accept a byte whenever the job queue has room; dropped bytes are
    // accepted too but never enter the queue.
    assign in_accept = push && !full;
    assign empty     = queue_empty;

    bfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .in_accept    (in_accept),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .job          (front_job),
        .job_valid    (front_job_valid)
    );

    bfe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_job_valid),
        .wr_job (front_job),
        .full   (full),
        .rd_en  (job_pop),
        .rd_job (head_job),
        .empty  (queue_empty)
    );

    // Expand the head job; retire it on the transfer of its last byte.
    bfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (head_job),
        .job_empty    (queue_empty),
        .job_pop      (job_pop),
        .pop          (pop),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame),
        .rejected     (rejected)
    );

endmodule

`default_nettype wire

FILE: tb/sv/bfe_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Scoreboard for the framed byte-stream encoder: watches input, result and
// configuration transfers, predicts the framed stream and compares each byte.
// Depends on bfe_pkg for widths, reset value and framing bytes.

module bfe_frame_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire logic                            full,
    input  wire logic [7:0]                      payload_byte,
    input  wire logic [bfe_pkg::LENGTH_BITS-1:0] frame_length,
    input  wire logic                            empty,
    input  wire logic                            pop,
    input  wire logic [7:0]                      out_byte,
    input  wire logic                            last_of_run,
    input  wire logic                            end_of_frame,
    input  wire logic                            rejected,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [bfe_pkg::MAXLEN_BITS-1:0] cfg_data,
    output int                                   outstanding,
    output int                                   errors
);
    import bfe_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eof;
        logic       rej;
    } stream_byte_t;

    stream_byte_t expected_stream[$];

    logic [MAXLEN_BITS-1:0] max_len;
    logic                   framing;
    logic                   discarding;
    logic [LENGTH_BITS-1:0] remaining;
    logic [SUM_BITS-1:0]    running_sum;

    function automatic void emit(input logic [7:0] data, input logic eof, input logic rej);
        stream_byte_t entry;
        entry.data = data;
        entry.last = 1'b0;
        entry.eof  = eof;
        entry.rej  = rej;
        expected_stream.push_back(entry);
    endfunction

    // Advance the encoder state by one input byte and queue the bytes it causes.
    task automatic encode_input(input logic [7:0] data, input logic [LENGTH_BITS-1:0] length);
        stream_byte_t tail;
        if (discarding) begin
            remaining = remaining - 1'b1;
            if (remaining == '0)
                discarding = 1'b0;
            return;
        end
        if (!framing) begin
            if (length == '0 || length > max_len) begin
                emit(8'h00, 1'b0, 1'b1);
                remaining  = (length == '0) ? '0 : length - 1'b1;
                discarding = (remaining != '0);
            end else begin
                emit(SYNC_BYTE0, 1'b0, 1'b0);
                emit(SYNC_BYTE1, 1'b0, 1'b0);
                emit(8'(length >> 8), 1'b0, 1'b0);
                emit(length[7:0], 1'b0, 1'b0);
                emit(data, 1'b0, 1'b0);
                running_sum = SUM_BITS'(data);
                remaining   = length - 1'b1;
                framing     = 1'b1;
            end
        end else begin
            emit(data, 1'b0, 1'b0);
            running_sum = running_sum + SUM_BITS'(data);
            remaining   = remaining - 1'b1;
        end
        if (framing && remaining == '0) begin
            emit(8'(running_sum >> 8), 1'b0, 1'b0);
            emit(running_sum[7:0], 1'b0, 1'b0);
            emit(END_BYTE0, 1'b0, 1'b0);
            emit(END_BYTE1, 1'b1, 1'b0);
            framing = 1'b0;
        end
        tail = expected_stream.pop_back();
        tail.last = 1'b1;
        expected_stream.push_back(tail);
    endtask

    function automatic bit field_differs(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (want === got)
            return 1'b0;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        stream_byte_t want;
        bit           bad;
        if (!rst_n) begin
            expected_stream.delete();
            max_len     = MAXLEN_RESET;
            framing     = 1'b0;
            discarding  = 1'b0;
            remaining   = '0;
            running_sum = '0;
            outstanding <= 0;
            errors      <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_stream.size() == 0) begin
                    bad = 1'b1;
                    $display("%0t: out_byte expected nothing, got %0h", $time, out_byte);
                end else begin
                    want = expected_stream.pop_front();
                    bad  = field_differs("out_byte", want.data, out_byte);
                    bad |= field_differs("last_of_run", 8'(want.last), 8'(last_of_run));
                    bad |= field_differs("end_of_frame", 8'(want.eof), 8'(end_of_frame));
                    bad |= field_differs("rejected", 8'(want.rej), 8'(rejected));
                end
                if (bad)
                    errors <= errors + 1;
            end
            if (push && !full)
                encode_input(payload_byte, frame_length);
            // A write takes effect for bytes accepted after this edge.
            if (cfg_valid && cfg_ready)
                max_len = cfg_data;
            outstanding <= expected_stream.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_binary_frame_encoder_sum_checksum_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Testbench top for binary_frame_encoder_sum_checksum_top: drives frames,
// random stalls and max_payload_len writes; bfe_frame_checker does the checking.
// Depends on bfe_pkg, bfe_frame_checker and the block's RTL.

module tb_binary_frame_encoder_sum_checksum_top;
    import bfe_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 12;    // let dropped bytes drain before a write
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 200;   // long receiver stall that backs up the input
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 10;

    localparam logic [MAXLEN_BITS-1:0] MAX_LEN_TOP = '1;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZEROS,
        FILL_ONES
    } fill_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [7:0]             payload_byte;
    logic [LENGTH_BITS-1:0] frame_length;
    logic                   empty;
    logic                   pop;
    logic [7:0]             out_byte;
    logic                   last_of_run;
    logic                   end_of_frame;
    logic                   rejected;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [MAXLEN_BITS-1:0] cfg_data;

    int outstanding;
    int errors;

    // Sender runs without gaps while set; the receiver owns its own burst flag.
    bit tx_burst;
    bit rx_burst;
    // Raised by the stimulus, cleared by the receiver once the long stall is done.
    bit hold_req;

    binary_frame_encoder_sum_checksum_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame),
        .rejected     (rejected),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    bfe_frame_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame),
        .rejected     (rejected),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .outstanding  (outstanding),
        .errors       (errors)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one input byte after a random gap and hold it until the transfer.
    // Push stays high on return so back-to-back bytes follow without a gap.
    task automatic send_item(input logic [7:0] data, input logic [LENGTH_BITS-1:0] length);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        payload_byte <= data;
        frame_length <= length;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // Send a whole frame: the length rides on the first byte, later bytes carry
    // random length values that the block must ignore. A zero length is one byte.
    task automatic send_frame(input logic [LENGTH_BITS-1:0] length, input fill_t fill);
        int         count;
        logic [7:0] data;
        count = (length == '0) ? 1 : int'(length);
        for (int i = 0; i < count; i++) begin
            unique case (fill)
                FILL_ZEROS: data = 8'h00;
                FILL_ONES:  data = 8'hFF;
                default:    data = 8'($urandom);
            endcase
            send_item(data, (i == 0) ? length : LENGTH_BITS'($urandom));
        end
    endtask

    // Drop push and wait until every predicted byte has been taken, then give
    // the block extra time, set by the argument, to finish bytes that cause no result.
    task automatic settle(input int extra);
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_max_len(input logic [MAXLEN_BITS-1:0] value);
        settle(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly accepted frames of small random size; under small limits some
    // over-limit frames whose tail gets dropped, and a few zero-length ones.
    // Every byte sent counts against the budget.
    task automatic random_frames(input int budget, input logic [MAXLEN_BITS-1:0] cap);
        int                     taken;
        int                     pick;
        int                     span;
        logic [LENGTH_BITS-1:0] length;
        taken = 0;
        while (taken < budget) begin
            pick     = $urandom_range(0, 99);
            tx_burst = ($urandom_range(0, 3) == 0);
            span     = (cap < 12) ? int'(cap) : 12;
            if (pick < 8 && cap > 12)
                span = (cap < 40) ? int'(cap) : 40;
            if (pick < 84 || cap > 40) begin
                length = LENGTH_BITS'($urandom_range(1, span));
                taken += int'(length);
            end else if (pick < 95) begin
                length = cap + LENGTH_BITS'($urandom_range(1, 6));
                taken += int'(length);
            end else begin
                length = '0;
                taken += 1;
            end
            send_frame(length, FILL_RANDOM);
        end
    endtask

    // Receiver: pop after a random gap per result, with bursts of no gaps and
    // one long stall on request so the block fills up and raises full.
    initial begin : receiver
        int gap;
        int taken;
        pop   <= 1'b0;
        taken = 0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (taken % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (hold_req)
                gap = HOLD_CYCLES;
            else
                gap = rx_burst ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                hold_req = 1'b0;
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            taken++;
        end
    end

    // Watchdog: end the run if no transfer of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb_binary_frame_encoder_sum_checksum_top NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [MAXLEN_BITS-1:0] cap;
        push         <= 1'b0;
        payload_byte <= '0;
        frame_length <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        tx_burst     = 1'b0;
        hold_req     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit of 992: one-byte frames (nine bytes out each) at both
        // byte extremes, short frames and a zero length.
        send_frame(15'd1, FILL_ZEROS);
        send_frame(15'd1, FILL_ONES);
        send_frame(15'd2, FILL_ONES);
        send_frame('0, FILL_RANDOM);
        send_frame(15'd3, FILL_RANDOM);
        // Long all-ones frame: nonzero length high byte and a wrapping checksum.
        send_frame(15'd260, FILL_ONES);

        // Limit 3: exactly at the limit, then one over.
        set_max_len(15'd3);
        send_frame(15'd3, FILL_RANDOM);
        send_frame(15'd4, FILL_RANDOM);

        // Smallest legal limit; drop a longer frame at top speed.
        set_max_len(15'd1);
        send_frame(15'd1, FILL_RANDOM);
        send_frame(15'd2, FILL_RANDOM);
        tx_burst = 1'b1;
        send_frame(15'd12, FILL_RANDOM);
        tx_burst = 1'b0;

        // Limit zero rejects everything.
        set_max_len('0);
        send_frame(15'd1, FILL_RANDOM);
        send_frame(15'd5, FILL_RANDOM);

        set_max_len(MAX_LEN_TOP);
        send_frame(15'd1, FILL_RANDOM);
        send_frame(15'd2, FILL_RANDOM);

        // Random phases across several limits; the long receiver stall lands
        // in the open-limit phase.
        for (int p = 0; p < 6; p++) begin
            unique case (p)
                0:       cap = MAXLEN_RESET;
                1:       cap = 15'd8;
                2:       cap = 15'd1;
                3:       cap = MAX_LEN_TOP;
                4:       cap = MAXLEN_BITS'($urandom_range(2, 40));
                default: cap = 15'd16;
            endcase
            set_max_len(cap);
            if (p == 3)
                hold_req = 1'b1;
            random_frames(PHASE_ITEMS, cap);
        end

        settle(DRAIN_CYCLES);
        if (errors == 0 && outstanding == 0)
            $display("tb_binary_frame_encoder_sum_checksum_top OK");
        else
            $display("tb_binary_frame_encoder_sum_checksum_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
sv/bfe_pkg.sv
sv/bfe_front.sv
sv/bfe_queue.sv
sv/bfe_back.sv
sv/binary_frame_encoder_sum_checksum_top.sv
tb/sv/bfe_frame_checker.sv
tb/sv/tb_binary_frame_encoder_sum_checksum_top.sv
